/* sv/udp_mpegts_pid_redactor_assert.svh */
// Assertion macros used by the queue; they expect clk and rst_n in scope.
`ifndef UDP_MPEGTS_PID_REDACTOR_ASSERT_SVH
`define UDP_MPEGTS_PID_REDACTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define UMPR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("umpr assertion failed");
`define UMPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("umpr assertion failed");
`else
`define UMPR_ASSERT_NOW(lbl, ante, cons)
`define UMPR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/umpr_pkg.sv */
package umpr_pkg;

    localparam int MAX_TS_PACKETS_DEF = 8;
    localparam int TS_SIZE            = 188;
    localparam int TS_BASE            = 42;
    localparam int QUEUE_DEPTH        = 4;

    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 16;
    localparam int PID_W      = 13;

    localparam logic [7:0]       SYNC_BYTE        = 8'h47;
    localparam logic [7:0]       NULL_PID_HI      = 8'h1F;
    localparam logic [7:0]       NULL_PID_LO      = 8'hFF;
    localparam logic [7:0]       NULL_AFC         = 8'h10;
    localparam logic [7:0]       PROTO_UDP        = 8'd17;
    localparam logic [PID_W-1:0] TARGET_PID_RESET = 13'h101;

    localparam logic [15:0] POS_PROTO  = 16'd23;
    localparam logic [15:0] POS_SRC_HI = 16'd34;
    localparam logic [15:0] POS_SRC_LO = 16'd35;
    localparam logic [15:0] POS_DST_HI = 16'd36;
    localparam logic [15:0] POS_DST_LO = 16'd37;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SPORT_MATCH = 2'd0,
        REG_DPORT_MATCH = 2'd1,
        REG_TARGET_PID  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [PID_W-1:0] target_pid;
    } cfg_t;

    // Bytes released by one accepted item, bytes[0] goes out first.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } grp_t;

endpackage

/* sv/umpr_ifs.sv */
interface umpr_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic [15:0] frame_length;
    logic        is_last;

    modport source (output valid, frame_byte, frame_length, is_last, input ready);
    modport sink   (input valid, frame_byte, frame_length, is_last, output ready);
endinterface

interface umpr_edit_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface umpr_reg_if;
    import umpr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [REG_IDX_W-1:0]  index;
    logic [REG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/umpr_cfg.sv */
module umpr_cfg (
    input  logic            clk,
    input  logic            rst_n,
    umpr_reg_if.sink        regs,
    output umpr_pkg::cfg_t  cfg
);
    import umpr_pkg::*;

    cfg_t cfg_reg;

    assign regs.ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sport      <= '0;
            cfg_reg.dport      <= '0;
            cfg_reg.target_pid <= TARGET_PID_RESET;
        end
        else if (regs.valid)
        begin
            unique case (reg_idx_t'(regs.index))
                REG_SPORT_MATCH: cfg_reg.sport      <= regs.data;
                REG_DPORT_MATCH: cfg_reg.dport      <= regs.data;
                REG_TARGET_PID:  cfg_reg.target_pid <= regs.data[PID_W-1:0];
                default:         cfg_reg            <= cfg_reg;
            endcase
        end
    end

endmodule

/* sv/umpr_front.sv */
module umpr_front #(
    parameter int MAX_TS_PACKETS = umpr_pkg::MAX_TS_PACKETS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    umpr_frame_if.sink      frame,
    input  umpr_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            push,
    output umpr_pkg::grp_t  grp
);
    import umpr_pkg::*;

    localparam int IDX_W = $clog2(MAX_TS_PACKETS + 1);

    localparam logic [7:0] K_SYNC   = 8'd0;
    localparam logic [7:0] K_PID_HI = 8'd1;
    localparam logic [7:0] K_PID_LO = 8'd2;
    localparam logic [7:0] K_AFC    = 8'd3;
    localparam logic [7:0] K_END    = 8'(TS_SIZE - 1);

    logic [15:0]      pos_reg, pos_next;
    logic             sel_reg, sel_next;
    logic             blank_reg, blank_next;
    logic             sync_reg, sync_next;
    logic [1:0][7:0]  held_reg, held_next;
    logic [1:0]       held_cnt_reg, held_cnt_next;
    logic [7:0]       k_reg, k_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic        accept;
    logic        in_ts;
    logic        past_base;
    logic [16:0] pkt_end;
    logic        fits;
    logic        hold;
    logic        release_grp;
    logic [7:0]  b;
    logic [7:0]  o;

    assign frame.ready = !q_full;
    assign accept      = frame.valid && frame.ready;
    assign b           = frame.frame_byte;

    assign past_base = pos_reg >= 16'(TS_BASE);
    assign in_ts     = past_base && (idx_reg < IDX_W'(MAX_TS_PACKETS));
    assign pkt_end   = 17'(TS_BASE) + (17'(idx_reg) + 17'd1) * 17'(TS_SIZE);
    assign fits      = pkt_end <= {1'b0, frame.frame_length};

    always_comb
    begin
        sel_next      = sel_reg;
        blank_next    = blank_reg;
        sync_next     = sync_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        o             = b;
        hold          = 1'b0;
        release_grp   = 1'b0;
        grp           = '0;

        // frame selection from the IP protocol byte and the UDP ports
        if (pos_reg == POS_PROTO)
            sel_next = (b == PROTO_UDP);
        if (pos_reg == POS_SRC_HI && cfg.sport != '0 && b != cfg.sport[15:8])
            sel_next = 1'b0;
        if (pos_reg == POS_SRC_LO && cfg.sport != '0 && b != cfg.sport[7:0])
            sel_next = 1'b0;
        if (pos_reg == POS_DST_HI && cfg.dport != '0 && b != cfg.dport[15:8])
            sel_next = 1'b0;
        if (pos_reg == POS_DST_LO && cfg.dport != '0 && b != cfg.dport[7:0])
            sel_next = 1'b0;

        if (in_ts)
        begin
            case (k_reg)
                K_SYNC:
                begin
                    blank_next = 1'b0;
                    sync_next  = sel_reg && fits && (b == SYNC_BYTE);
                    hold       = sync_next;
                end
                K_PID_HI:
                begin
                    hold = sync_reg;
                end
                K_PID_LO:
                begin
                    if (sync_reg && {held_reg[1][4:0], b} == cfg.target_pid)
                    begin
                        blank_next   = 1'b1;
                        held_next[1] = NULL_PID_HI;
                        o            = NULL_PID_LO;
                    end
                    sync_next = 1'b0;
                end
                K_AFC:
                begin
                    if (blank_reg)
                        o = NULL_AFC;
                end
                default:
                begin
                    if (blank_reg)
                        o = '0;
                end
            endcase
        end

        // hold candidate sync and PID bytes, else flush them ahead of this one
        if (hold && !frame.is_last && held_cnt_reg < 2'd2)
        begin
            held_next[held_cnt_reg[0]] = b;
            held_cnt_next              = held_cnt_reg + 2'd1;
        end
        else
        begin
            release_grp   = 1'b1;
            held_cnt_next = '0;
        end

        grp.last  = frame.is_last;
        grp.count = held_cnt_reg + 2'd1;
        case (held_cnt_reg)
            2'd0:
            begin
                grp.bytes[0] = o;
            end
            2'd1:
            begin
                grp.bytes[0] = held_next[0];
                grp.bytes[1] = o;
            end
            default:
            begin
                grp.bytes[0] = held_next[0];
                grp.bytes[1] = held_next[1];
                grp.bytes[2] = o;
            end
        endcase

        if (frame.is_last)
        begin
            pos_next      = '0;
            sel_next      = 1'b0;
            blank_next    = 1'b0;
            sync_next     = 1'b0;
            held_next     = '0;
            held_cnt_next = '0;
            k_next        = '0;
            idx_next      = '0;
        end
        else
        begin
            if (pos_reg != 16'hFFFF)
                pos_next = pos_reg + 16'd1;
            if (in_ts)
            begin
                if (k_reg == K_END)
                begin
                    k_next   = '0;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 8'd1;
                end
            end
        end
    end

    assign push = accept && release_grp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sel_reg      <= 1'b0;
            blank_reg    <= 1'b0;
            sync_reg     <= 1'b0;
            held_reg     <= '0;
            held_cnt_reg <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            sel_reg      <= sel_next;
            blank_reg    <= blank_next;
            sync_reg     <= sync_next;
            held_reg     <= held_next;
            held_cnt_reg <= held_cnt_next;
            k_reg        <= k_next;
            idx_reg      <= idx_next;
        end
    end

endmodule

/* sv/umpr_queue.sv */
module umpr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  umpr_pkg::grp_t  grp_in,
    output logic            full,
    input  logic            pop,
    output umpr_pkg::grp_t  head,
    output logic            empty
);
    import umpr_pkg::*;
    `include "udp_mpegts_pid_redactor_assert.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    grp_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= grp_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `UMPR_ASSERT_NOW(a_no_push_when_full, full, !push)
    `UMPR_ASSERT_NOW(a_no_pop_when_empty, empty, !pop)
    `UMPR_ASSERT_NEXT(a_count_rises, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `UMPR_ASSERT_NOW(a_head_not_blank, !empty, head.count != 2'd0)

endmodule

/* sv/umpr_back.sv */
module umpr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  umpr_pkg::grp_t  head,
    input  logic            empty,
    output logic            pop,
    umpr_edit_if.source     edited
);
    import umpr_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic load;
    logic final_byte;

    assign load       = !empty && (!valid_reg || edited.ready);
    assign final_byte = idx_reg == (head.count - 2'd1);
    assign pop        = load && final_byte;

    assign edited.valid    = valid_reg;
    assign edited.out_byte = byte_reg;
    assign edited.out_last = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= head.last && final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            // step through the bytes of the head group, pop it after its last
            if (pop)
                idx_reg <= '0;
            else if (load)
                idx_reg <= idx_reg + 2'd1;

            if (load)
                valid_reg <= 1'b1;
            else if (edited.ready)
                valid_reg <= 1'b0;
        end
    end

endmodule

/* sv/udp_mpegts_pid_redactor.sv */
// A passed byte is written into the group queue at the edge that accepts it, then into the
// output register that drives edited; sync and PID bytes of a candidate packet wait for
// the PID low byte and then leave with it. Throughput: one byte per cycle in and out;
// input stalls only while four groups wait, output while edited is not ready. A group of
// three bytes drains through the single output register while the queue absorbs input.
// Reset: rst_n, asynchronous, clears frame state, port checks off, target PID 0x101.
module udp_mpegts_pid_redactor #(
    parameter int MAX_TS_PACKETS = umpr_pkg::MAX_TS_PACKETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    umpr_frame_if.sink  frame,
    umpr_edit_if.source edited,
    umpr_reg_if.sink    regs
);
    import umpr_pkg::*;

    cfg_t cfg;
    grp_t grp;
    grp_t head;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    umpr_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .cfg   (cfg)
    );

    umpr_front #(
        .MAX_TS_PACKETS (MAX_TS_PACKETS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push),
        .grp    (grp)
    );

    umpr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .grp_in (grp),
        .full   (q_full),
        .pop    (pop),
        .head   (head),
        .empty  (q_empty)
    );

    umpr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (q_empty),
        .pop    (pop),
        .edited (edited)
    );

endmodule
